// ===== sv/jbf_pkg.sv =====
// ---------------------------------------------------------------------------
// jbf_pkg
// shared constants, codes and types of the joint bilateral filter core
// ---------------------------------------------------------------------------
`default_nettype none

package jbf_pkg;

  localparam int DEF_MAX_LINE_WIDTH     = 1024;
  localparam int DEF_MAX_RADIUS         = 3;
  localparam int DEF_COLOUR_TABLE_DEPTH = 1024;
  localparam int DEF_MAX_CHANNELS       = 3;
  localparam int MAX_HEIGHT             = 4096;

  localparam int OX_W = 10;
  localparam int OY_W = 12;
  localparam int Q_W  = 16;

  localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_RADIUS         = 3'd2;
  localparam logic [2:0] REG_GUIDE_CHANNELS = 3'd3;
  localparam logic [2:0] REG_SIGNAL_LAYERS  = 3'd4;

  localparam logic [10:0] RST_FRAME_WIDTH    = 11'd1024;
  localparam logic [12:0] RST_FRAME_HEIGHT   = 13'd480;
  localparam logic [1:0]  RST_RADIUS         = 2'd3;
  localparam logic [1:0]  RST_GUIDE_CHANNELS = 2'd3;
  localparam logic [1:0]  RST_SIGNAL_LAYERS  = 2'd1;

  localparam logic [1:0] FUNC_PIXEL  = 2'd0;
  localparam logic [1:0] FUNC_COLOUR = 2'd1;
  localparam logic [1:0] FUNC_DIST   = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } jbf_div_stat_t;

endpackage

`default_nettype wire

// ===== sv/jbf_div.sv =====
// ---------------------------------------------------------------------------
// jbf_div
// restoring divider, one quotient bit per cycle, quotient known to fit Q_W
// ---------------------------------------------------------------------------
`default_nettype none

module jbf_div
  import jbf_pkg::*;
#(
  parameter int NUM_W = 39,
  parameter int DEN_W = 23
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output jbf_div_stat_t         stat,
  output logic [Q_W-1:0]        quotient
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [Q_W-1:0]   q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;

  assign trial = {rem, q[Q_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem <= dividend[NUM_W-1:Q_W];
      q   <= dividend[Q_W-1:0];
      den <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= DEN_W'(trial - {1'b0, den});
        q   <= {q[Q_W-2:0], 1'b1};
      end else begin
        rem <= trial[DEN_W-1:0];
        q   <= {q[Q_W-2:0], 1'b0};
      end
    end
  end

  assign stat     = '{busy: busy, done: done};
  assign quotient = q;

endmodule

`default_nettype wire

// ===== sv/joint_bilateral_filter_core.sv =====
// ---------------------------------------------------------------------------
// joint_bilateral_filter_core
// table driven joint bilateral filter over a raster pixel stream
// ---------------------------------------------------------------------------
// One item is taken at a time. For each output that a pixel releases (at most
// (R+1)^2 at a frame corner, usually one or none), the core visits every
// position of the (2R+1)^2 window and waits out any output stall: each
// in-frame neighbour adds a serial read of the line store memories, a colour
// and distance table read, a weight multiply and an accumulate, and each of
// the L signal layers goes through one shared bit-serial divider.
// Unwritten line store or table entries read as undefined data.
`default_nettype none

module joint_bilateral_filter_core
  import jbf_pkg::*;
#(
  parameter int MAX_LINE_WIDTH     = DEF_MAX_LINE_WIDTH,
  parameter int MAX_RADIUS         = DEF_MAX_RADIUS,
  parameter int COLOUR_TABLE_DEPTH = DEF_COLOUR_TABLE_DEPTH,
  parameter int MAX_CHANNELS       = DEF_MAX_CHANNELS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       func,
  input  wire logic [7:0]       guide_0,
  input  wire logic [7:0]       guide_1,
  input  wire logic [7:0]       guide_2,
  input  wire logic [15:0]      signal_0,
  input  wire logic [15:0]      signal_1,
  input  wire logic [15:0]      signal_2,
  input  wire logic [9:0]       table_index,
  input  wire logic [15:0]      table_weight,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [OX_W-1:0]       out_x,
  output logic [OY_W-1:0]       out_y,
  output logic [Q_W-1:0]        out_value_0,
  output logic [Q_W-1:0]        out_value_1,
  output logic [Q_W-1:0]        out_value_2,
  output logic                  last_of_run,
  output logic                  last_of_frame
);

  localparam int LC    = 2 * MAX_RADIUS + 1;
  localparam int DD    = LC * LC;
  localparam int CW    = $clog2(MAX_LINE_WIDTH);
  localparam int SW    = $clog2(LC);
  localparam int AW    = $clog2(LC * MAX_LINE_WIDTH);
  localparam int CTW   = $clog2(COLOUR_TABLE_DEPTH);
  localparam int DW    = $clog2(DD);
  localparam int SUM_W = 17 + $clog2(DD);
  localparam int NUM_W = SUM_W + Q_W;
  localparam int CMAX  = (MAX_CHANNELS < 3) ? MAX_CHANNELS : 3;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PIX   = 4'd1;
  localparam logic [3:0] S_CREAD = 4'd2;
  localparam logic [3:0] S_CLAT  = 4'd3;
  localparam logic [3:0] S_NADDR = 4'd4;
  localparam logic [3:0] S_NDAT  = 4'd5;
  localparam logic [3:0] S_WMUL  = 4'd6;
  localparam logic [3:0] S_WRND  = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_DIVS  = 4'd9;
  localparam logic [3:0] S_DIVW  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  // configuration registers
  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [1:0]  radius;
  logic [1:0]  guide_channels;
  logic [1:0]  signal_layers;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= RST_FRAME_WIDTH;
      frame_height   <= RST_FRAME_HEIGHT;
      radius         <= RST_RADIUS;
      guide_channels <= RST_GUIDE_CHANNELS;
      signal_layers  <= RST_SIGNAL_LAYERS;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_FRAME_WIDTH:    frame_width    <= pwdata[10:0];
        REG_FRAME_HEIGHT:   frame_height   <= pwdata[12:0];
        REG_RADIUS:         radius         <= pwdata[1:0];
        REG_GUIDE_CHANNELS: guide_channels <= pwdata[1:0];
        REG_SIGNAL_LAYERS:  signal_layers  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_FRAME_WIDTH:    prdata = 32'(frame_width);
      REG_FRAME_HEIGHT:   prdata = 32'(frame_height);
      REG_RADIUS:         prdata = 32'(radius);
      REG_GUIDE_CHANNELS: prdata = 32'(guide_channels);
      REG_SIGNAL_LAYERS:  prdata = 32'(signal_layers);
      default:            prdata = '0;
    endcase
  end

  // effective frame settings
  logic [CW:0] w_eff;
  logic [12:0] h_eff;
  logic [1:0]  r_eff;
  logic [1:0]  c_eff;
  logic [1:0]  l_eff;

  always_comb begin
    if (frame_width == '0) w_eff = (CW+1)'(1);
    else if (13'(frame_width) > 13'(MAX_LINE_WIDTH)) w_eff = (CW+1)'(MAX_LINE_WIDTH);
    else w_eff = (CW+1)'(frame_width);
    if (frame_height == '0) h_eff = 13'd1;
    else if (frame_height > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
    else h_eff = frame_height;
    r_eff = (32'(radius) > MAX_RADIUS) ? 2'(MAX_RADIUS) : radius;
    if (guide_channels == '0) c_eff = 2'd1;
    else if (32'(guide_channels) > CMAX) c_eff = 2'(CMAX);
    else c_eff = guide_channels;
    l_eff = (signal_layers == '0) ? 2'd1 : signal_layers;
  end

  function automatic logic [AW-1:0] line_addr(input logic [SW-1:0] s, input logic [CW-1:0] x);
    return AW'(s) * AW'(MAX_LINE_WIDTH) + AW'(x);
  endfunction

  // memories
  logic [23:0] guide_mem [LC*MAX_LINE_WIDTH];
  logic [47:0] signal_mem [LC*MAX_LINE_WIDTH];
  logic [15:0] colour_mem [COLOUR_TABLE_DEPTH];
  logic [15:0] dist_mem [DD];

  logic          line_we;
  logic [AW-1:0] line_waddr;
  logic          line_re;
  logic [AW-1:0] line_raddr;
  logic [23:0]   gdat;
  logic [47:0]   sdat;
  logic          tab_re;
  logic [CTW-1:0] cidx;
  logic [DW-1:0]  kidx;
  logic [15:0]   cw_q;
  logic [15:0]   dw_q;

  // state
  logic [3:0]      state;
  logic [1:0]      pfunc;
  logic [23:0]     pguide;
  logic [47:0]     psignal;
  logic [CW-1:0]   col;
  logic [OY_W-1:0] row;
  logic [SW-1:0]   row_slot;
  logic [CW-1:0]   ox;
  logic [CW-1:0]   xlo;
  logic [CW-1:0]   xhi;
  logic [OY_W-1:0] oy;
  logic [OY_W-1:0] yhi;
  logic [SW-1:0]   oslot;
  logic [2:0]      ix;
  logic [2:0]      iy;
  logic [23:0]     gc;
  logic [47:0]     nsig;
  logic [31:0]     prod;
  logic [15:0]     w;
  logic [SUM_W-1:0] sum;
  logic [NUM_W-1:0] num [3];
  logic [Q_W-1:0]  val [3];
  logic [1:0]      lay;

  logic in_xfer;
  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_xfer && func == FUNC_COLOUR && 13'(table_index) < 13'(COLOUR_TABLE_DEPTH)) begin
      colour_mem[CTW'(table_index)] <= table_weight;
    end
    if (tab_re) begin
      cw_q <= colour_mem[cidx];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && func == FUNC_DIST && 13'(table_index) < 13'(DD)) begin
      dist_mem[DW'(table_index)] <= table_weight;
    end
    if (tab_re) begin
      dw_q <= dist_mem[kidx];
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      guide_mem[line_waddr] <= pguide;
    end
    if (line_re) begin
      gdat <= guide_mem[line_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      signal_mem[line_waddr] <= psignal;
    end
    if (line_re) begin
      sdat <= signal_mem[line_raddr];
    end
  end

  // pixel placement and output range
  logic            wrap;
  logic [CW-1:0]   cx;
  logic [OY_W-1:0] cy;
  logic [SW-1:0]   cslot;
  logic            y_any;
  logic            x_any;
  logic [OY_W-1:0] ylo_c;
  logic [OY_W-1:0] yhi_c;
  logic [CW-1:0]   xlo_c;
  logic [CW-1:0]   xhi_c;
  logic signed [SW+1:0] oslot_t;
  logic [SW-1:0]   oslot_c;

  always_comb begin
    wrap  = (13'(col) >= 13'(w_eff)) || (13'(row) >= h_eff);
    cx    = wrap ? '0 : col;
    cy    = wrap ? '0 : row;
    cslot = wrap ? '0 : row_slot;
    y_any = 1'b1;
    ylo_c = cy;
    yhi_c = cy;
    if (13'(cy) == h_eff - 13'd1) begin
      ylo_c = (cy >= OY_W'(r_eff)) ? cy - OY_W'(r_eff) : '0;
    end else if (cy >= OY_W'(r_eff)) begin
      ylo_c = cy - OY_W'(r_eff);
      yhi_c = ylo_c;
    end else begin
      y_any = 1'b0;
    end
    x_any = 1'b1;
    xlo_c = cx;
    xhi_c = cx;
    if ((CW+1)'(cx) == w_eff - (CW+1)'(1)) begin
      xlo_c = (cx >= CW'(r_eff)) ? cx - CW'(r_eff) : '0;
    end else if (cx >= CW'(r_eff)) begin
      xlo_c = cx - CW'(r_eff);
      xhi_c = xlo_c;
    end else begin
      x_any = 1'b0;
    end
    oslot_t = $signed((SW+2)'(cslot)) - $signed((SW+2)'(cy - ylo_c));
    if (oslot_t < 0) oslot_t = oslot_t + $signed((SW+2)'(LC));
    oslot_c = oslot_t[SW-1:0];
  end

  // neighbour position
  logic signed [14:0]   xx;
  logic signed [14:0]   yy;
  logic signed [SW+2:0] nslot_t;
  logic [SW-1:0]        nslot;
  logic                 skip;
  logic                 win_last;

  always_comb begin
    xx = $signed(15'(ox)) + $signed(15'(ix)) - $signed(15'(r_eff));
    yy = $signed(15'(oy)) + $signed(15'(iy)) - $signed(15'(r_eff));
    nslot_t = $signed((SW+3)'(oslot)) + $signed((SW+3)'(iy)) - $signed((SW+3)'(r_eff));
    if (nslot_t < 0) nslot_t = nslot_t + $signed((SW+3)'(LC));
    else if (nslot_t >= $signed((SW+3)'(LC))) nslot_t = nslot_t - $signed((SW+3)'(LC));
    nslot = nslot_t[SW-1:0];
    skip = (ix == 3'(r_eff) && iy == 3'(r_eff)) || xx < 0 || yy < 0
        || xx >= $signed(15'(w_eff)) || yy >= $signed(15'(h_eff));
    win_last = (ix == {r_eff, 1'b0}) && (iy == {r_eff, 1'b0});
  end

  // colour difference and table indexes
  logic [9:0] diff;
  logic [7:0] ga;
  logic [7:0] gb;

  always_comb begin
    diff = '0;
    for (int c = 0; c < 3; c++) begin
      ga = gc[c*8 +: 8];
      gb = gdat[c*8 +: 8];
      if (c < 32'(c_eff)) begin
        diff = diff + 10'((ga > gb) ? ga - gb : gb - ga);
      end
    end
    if (13'(diff) > 13'(COLOUR_TABLE_DEPTH - 1)) cidx = CTW'(COLOUR_TABLE_DEPTH - 1);
    else cidx = CTW'(diff);
    kidx = DW'(8'(ix) * 8'({r_eff, 1'b1}) + 8'(iy));
  end

  // divider
  jbf_div_stat_t   div_stat;
  logic [Q_W-1:0]  div_q;
  logic            div_start;
  logic [NUM_W-1:0] div_num;

  assign div_start = (state == S_DIVS);
  assign div_num   = num[lay] + NUM_W'(sum >> 1);

  jbf_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (sum),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_comb begin
    line_we    = (state == S_PIX) && (pfunc == FUNC_PIXEL);
    line_waddr = line_addr(cslot, cx);
    line_re    = 1'b0;
    line_raddr = line_addr(oslot, ox);
    tab_re     = (state == S_NDAT);
    if (state == S_CREAD) begin
      line_re = 1'b1;
    end else if (state == S_NADDR && !skip) begin
      line_re    = 1'b1;
      line_raddr = line_addr(nslot, CW'(xx));
    end
  end

  logic out_load;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      col      <= '0;
      row      <= '0;
      row_slot <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer && func == FUNC_PIXEL) state <= S_PIX;
        end
        S_PIX: begin
          if ((CW+1)'(cx) + (CW+1)'(1) >= w_eff) begin
            col <= '0;
            if (13'(cy) + 13'd1 >= h_eff) begin
              row      <= '0;
              row_slot <= '0;
            end else begin
              row      <= cy + 1'b1;
              row_slot <= (32'(cslot) == LC - 1) ? '0 : cslot + 1'b1;
            end
          end else begin
            col      <= cx + 1'b1;
            row      <= cy;
            row_slot <= cslot;
          end
          state <= (y_any && x_any) ? S_CREAD : S_IDLE;
        end
        S_CREAD: state <= S_CLAT;
        S_CLAT:  state <= S_NADDR;
        S_NADDR: begin
          if (!skip) state <= S_NDAT;
          else if (win_last) state <= S_DIVS;
        end
        S_NDAT: state <= S_WMUL;
        S_WMUL: state <= S_WRND;
        S_WRND: state <= S_ACC;
        S_ACC:  state <= win_last ? S_DIVS : S_NADDR;
        S_DIVS: state <= S_DIVW;
        S_DIVW: begin
          if (div_stat.done) state <= (lay == l_eff - 2'd1) ? S_OUT : S_DIVS;
        end
        S_OUT: begin
          if (out_load) begin
            if (ox == xhi && oy == yhi) state <= S_IDLE;
            else state <= S_CREAD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pfunc   <= func;
      pguide  <= {guide_2, guide_1, guide_0};
      psignal <= {signal_2, signal_1, signal_0};
    end
    case (state)
      S_PIX: begin
        ox    <= xlo_c;
        xlo   <= xlo_c;
        xhi   <= xhi_c;
        oy    <= ylo_c;
        yhi   <= yhi_c;
        oslot <= oslot_c;
      end
      S_CLAT: begin
        gc   <= gdat;
        sum  <= SUM_W'(65536);
        ix   <= '0;
        iy   <= '0;
        lay  <= '0;
        for (int l = 0; l < 3; l++) begin
          num[l] <= NUM_W'(sdat[l*16 +: 16]) << 16;
          val[l] <= '0;
        end
      end
      S_NADDR, S_ACC: begin
        if (state == S_ACC) begin
          sum <= sum + SUM_W'(w);
          for (int l = 0; l < 3; l++) begin
            num[l] <= num[l] + NUM_W'(nsig[l*16 +: 16] * 32'(w));
          end
        end
        if (state == S_ACC || skip) begin
          if (iy == {r_eff, 1'b0}) begin
            iy <= '0;
            if (!win_last) ix <= ix + 1'b1;
          end else begin
            iy <= iy + 1'b1;
          end
        end
      end
      S_NDAT: nsig <= sdat;
      S_WMUL: prod <= cw_q * dw_q;
      S_WRND: w    <= 16'((33'(prod) + 33'd32768) >> 16);
      S_DIVW: begin
        if (div_stat.done) begin
          val[lay] <= div_q;
          lay      <= lay + 1'b1;
        end
      end
      S_OUT: begin
        if (out_load) begin
          if (ox == xhi) begin
            ox    <= xlo;
            oy    <= oy + 1'b1;
            oslot <= (32'(oslot) == LC - 1) ? '0 : oslot + 1'b1;
          end else begin
            ox <= ox + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x         <= OX_W'(ox);
      out_y         <= oy;
      out_value_0   <= val[0];
      out_value_1   <= val[1];
      out_value_2   <= val[2];
      last_of_run   <= (ox == xhi) && (oy == yhi);
      last_of_frame <= ((CW+1)'(ox) == w_eff - (CW+1)'(1)) && (13'(oy) == h_eff - 13'd1);
    end
  end

  // checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_PIXEL |=> !in_ready)
    else $error("second item taken while busy");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIVW)
    else $error("divider finished outside its wait state");

  a_unused_layers: assert property (@(posedge clk) disable iff (rst)
    out_valid && l_eff == 2'd1 |-> out_value_1 == '0 && out_value_2 == '0)
    else $error("unused layer not zero");

endmodule

`default_nettype wire

// ===== sim/tb_joint_bilateral_filter_core.sv =====
// ---------------------------------------------------------------------------
// tb_joint_bilateral_filter_core
// self-checking bench for the table driven joint bilateral filter core
// ---------------------------------------------------------------------------
// Loads both weight tables and streams whole raster frames over a range of
// register settings. A local filter model predicts every output pixel when
// its input pixel is transferred, and a monitor checks each output transfer
// field by field against the oldest prediction. Both handshakes idle at
// random, with burst phases that never idle.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_joint_bilateral_filter_core;
  import jbf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int LINES = 2 * DEF_MAX_RADIUS + 1;
  localparam int DIST_DEPTH = LINES * LINES;
  localparam int WDOG_LIMIT = 20000;
  // random guide levels stay small so only the low colour entries are reached
  localparam int GUIDE_MAX = 31;
  localparam int COLOUR_LOADED = 3 * GUIDE_MAX + 1;
  localparam int ITEM_TARGET = 340;

  typedef struct packed {
    logic [OX_W-1:0] x;
    logic [OY_W-1:0] y;
    logic [Q_W-1:0]  v0;
    logic [Q_W-1:0]  v1;
    logic [Q_W-1:0]  v2;
    logic            last_run;
    logic            last_frame;
  } pix_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = '0;
  logic [7:0] guide_0 = '0, guide_1 = '0, guide_2 = '0;
  logic [15:0] signal_0 = '0, signal_1 = '0, signal_2 = '0;
  logic [9:0] table_index = '0;
  logic [15:0] table_weight = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OX_W-1:0] out_x;
  logic [OY_W-1:0] out_y;
  logic [Q_W-1:0] out_value_0, out_value_1, out_value_2;
  logic last_of_run, last_of_frame;

  joint_bilateral_filter_core uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // filter model state
  bit [7:0]  guide_mem [LINES][DEF_MAX_LINE_WIDTH][3];
  bit [15:0] sig_mem   [LINES][DEF_MAX_LINE_WIDTH][3];
  bit [15:0] colour_tab [DEF_COLOUR_TABLE_DEPTH];
  bit [15:0] dist_tab [DIST_DEPTH];
  int col_cnt = 0, row_cnt = 0;
  bit [10:0] cfg_width = RST_FRAME_WIDTH;
  bit [12:0] cfg_height = RST_FRAME_HEIGHT;
  bit [1:0] cfg_radius = RST_RADIUS, cfg_chans = RST_GUIDE_CHANNELS;
  bit [1:0] cfg_layers = RST_SIGNAL_LAYERS;

  pix_out_t filtered_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit burst = 1'b0;
  int pixels_sent = 0;
  int items_sent = 0;

  function automatic int eff_width();
    return cfg_width == 0 ? 1 : (cfg_width > DEF_MAX_LINE_WIDTH ? DEF_MAX_LINE_WIDTH : cfg_width);
  endfunction

  function automatic int eff_height();
    return cfg_height == 0 ? 1 : (cfg_height > MAX_HEIGHT ? MAX_HEIGHT : cfg_height);
  endfunction

  function automatic pix_out_t filter_at(int ox, int oy, int fw, int fh, int r, int nc, int nl);
    longint unsigned num[3];
    longint unsigned wsum, w, q;
    int cs, s, diff, d, ci, ki, xx, yy;
    pix_out_t o;
    cs = oy % LINES;
    wsum = 65536;
    for (int l = 0; l < 3; l++) num[l] = longint'(sig_mem[cs][ox][l]) << 16;
    for (int dx = -r; dx <= r; dx++) begin
      for (int dy = -r; dy <= r; dy++) begin
        xx = ox + dx;
        yy = oy + dy;
        if ((dx == 0 && dy == 0) || xx < 0 || xx >= fw || yy < 0 || yy >= fh) continue;
        s = yy % LINES;
        diff = 0;
        for (int c = 0; c < nc; c++) begin
          d = int'(guide_mem[cs][ox][c]) - int'(guide_mem[s][xx][c]);
          diff += d < 0 ? -d : d;
        end
        ci = diff < DEF_COLOUR_TABLE_DEPTH ? diff : DEF_COLOUR_TABLE_DEPTH - 1;
        ki = (dx + r) * (2 * r + 1) + (dy + r);
        w = (longint'(colour_tab[ci]) * longint'(dist_tab[ki]) + 32768) >> 16;
        wsum += w;
        for (int l = 0; l < 3; l++) num[l] += longint'(sig_mem[s][xx][l]) * w;
      end
    end
    o.x = ox[OX_W-1:0];
    o.y = oy[OY_W-1:0];
    q = nl > 0 ? (num[0] + wsum / 2) / wsum : 0;
    o.v0 = q[15:0];
    q = nl > 1 ? (num[1] + wsum / 2) / wsum : 0;
    o.v1 = q[15:0];
    q = nl > 2 ? (num[2] + wsum / 2) / wsum : 0;
    o.v2 = q[15:0];
    o.last_run = 1'b0;
    o.last_frame = (ox == fw - 1 && oy == fh - 1);
    return o;
  endfunction

  task automatic predict_item();
    int fw, fh, r, nc, nl, slot, ylo, yhi, xlo, xhi, n;
    pix_out_t o;
    case (func)
      FUNC_COLOUR: colour_tab[table_index] = table_weight;
      FUNC_DIST: if (table_index < DIST_DEPTH) dist_tab[table_index] = table_weight;
      FUNC_PIXEL: begin
        fw = eff_width();
        fh = eff_height();
        r = cfg_radius;
        nc = cfg_chans == 0 ? 1 : cfg_chans;
        nl = cfg_layers == 0 ? 1 : cfg_layers;
        if (col_cnt >= fw || row_cnt >= fh) begin
          col_cnt = 0;
          row_cnt = 0;
        end
        slot = row_cnt % LINES;
        guide_mem[slot][col_cnt] = '{guide_0, guide_1, guide_2};
        sig_mem[slot][col_cnt] = '{signal_0, signal_1, signal_2};
        if (row_cnt == fh - 1) begin
          ylo = row_cnt >= r ? row_cnt - r : 0;
          yhi = row_cnt;
        end else if (row_cnt >= r) begin
          ylo = row_cnt - r;
          yhi = ylo;
        end else begin
          ylo = 1;
          yhi = 0;
        end
        if (col_cnt == fw - 1) begin
          xlo = col_cnt >= r ? col_cnt - r : 0;
          xhi = col_cnt;
        end else if (col_cnt >= r) begin
          xlo = col_cnt - r;
          xhi = xlo;
        end else begin
          xlo = 1;
          xhi = 0;
        end
        n = 0;
        for (int oy = ylo; oy <= yhi; oy++) begin
          for (int ox = xlo; ox <= xhi; ox++) begin
            filtered_q.push_back(filter_at(ox, oy, fw, fh, r, nc, nl));
            n++;
          end
        end
        if (n > 0) filtered_q[filtered_q.size() - 1].last_run = 1'b1;
        col_cnt++;
        if (col_cnt >= fw) begin
          col_cnt = 0;
          row_cnt++;
          if (row_cnt >= fh) row_cnt = 0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] f, input logic [7:0] g0, g1, g2,
                           input logic [15:0] s0, s1, s2,
                           input logic [9:0] idx, input logic [15:0] wt);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    guide_0 <= g0;
    guide_1 <= g1;
    guide_2 <= g2;
    signal_0 <= s0;
    signal_1 <= s1;
    signal_2 <= s2;
    table_index <= idx;
    table_weight <= wt;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_item();
    items_sent++;
    if (f == FUNC_PIXEL) pixels_sent++;
  endtask

  task automatic send_random_pixel();
    send_item(FUNC_PIXEL, 8'($urandom_range(0, GUIDE_MAX)), 8'($urandom_range(0, GUIDE_MAX)),
              8'($urandom_range(0, GUIDE_MAX)), 16'($urandom), 16'($urandom), 16'($urandom),
              10'($urandom), 16'($urandom));
  endtask

  task automatic wait_drained();
    while (filtered_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    in_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:    cfg_width = value[10:0];
      REG_FRAME_HEIGHT:   cfg_height = value[12:0];
      REG_RADIUS:         cfg_radius = value[1:0];
      REG_GUIDE_CHANNELS: cfg_chans = value[1:0];
      REG_SIGNAL_LAYERS:  cfg_layers = value[1:0];
      default: ;
    endcase
  endtask

  task automatic setup_frame(input int w, h, r, c, l);
    write_reg(REG_FRAME_WIDTH, 32'(w));
    write_reg(REG_FRAME_HEIGHT, 32'(h));
    write_reg(REG_RADIUS, 32'(r));
    write_reg(REG_GUIDE_CHANNELS, 32'(c));
    write_reg(REG_SIGNAL_LAYERS, 32'(l));
  endtask

  task automatic load_tables();
    for (int i = 0; i < COLOUR_LOADED; i++)
      send_item(FUNC_COLOUR, 0, 0, 0, 0, 0, 0, 10'(i), 16'($urandom));
    for (int i = 0; i < DIST_DEPTH; i++)
      send_item(FUNC_DIST, 0, 0, 0, 0, 0, 0, 10'(i), 16'($urandom));
  endtask

  task automatic test_extremes();
    logic [7:0] g;
    logic [15:0] s;
    setup_frame(4, 3, 3, 3, 3);
    send_item(FUNC_COLOUR, 0, 0, 0, 0, 0, 0, 10'd1023, 16'hffff);
    send_item(FUNC_COLOUR, 0, 0, 0, 0, 0, 0, 10'd765, 16'h0000);
    send_item(FUNC_DIST, 0, 0, 0, 0, 0, 0, 10'd1023, 16'h0000);
    send_item(FUNC_DIST, 0, 0, 0, 0, 0, 0, 10'd48, 16'hffff);
    send_item(FUNC_NONE, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff, 10'h3ff, 16'hffff);
    for (int i = 0; i < 12; i++) begin
      g = ((i + i / 4) % 2) ? 8'hff : 8'h00;
      s = (i % 3 == 0) ? 16'hffff : 16'h0000;
      send_item(FUNC_PIXEL, g, ~g, g, s, ~s, s, 10'h3ff, 16'hffff);
      // hold off mid frame until the output side has caught up
      if (i == 5) begin
        in_valid <= 1'b0;
        wait_drained();
      end
    end
  endtask

  task automatic test_size_clamps();
    setup_frame(0, 0, 0, 0, 0);
    repeat (2) send_random_pixel();
    setup_frame(2047, 8191, 1, 2, 2);
    repeat (5) send_random_pixel();
    // shrinking below the current position restarts the frame
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 2);
    repeat (4) send_random_pixel();
  endtask

  task automatic test_random_frames();
    int w, h, n;
    while (items_sent < ITEM_TARGET) begin
      burst = ($urandom_range(0, 3) == 0);
      setup_frame($urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 8),
                  $urandom_range(1, 6), $urandom_range(0, 3),
                  $urandom_range(0, 3), $urandom_range(0, 3));
      repeat ($urandom_range(0, 3))
        send_item(FUNC_COLOUR, 0, 0, 0, 0, 0, 0, $urandom, $urandom);
      repeat ($urandom_range(0, 2))
        send_item(FUNC_DIST, 0, 0, 0, 0, 0, 0, $urandom_range(0, 63), $urandom);
      w = eff_width();
      h = eff_height();
      n = w * h;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_item(FUNC_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
        send_random_pixel();
      end
    end
    burst = 1'b0;
  endtask

  // output side
  initial begin
    pix_out_t got, exp_pix;
    int stall;
    forever begin
      stall = burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      got = '{out_x, out_y, out_value_0, out_value_1, out_value_2,
              last_of_run, last_of_frame};
      @(posedge clk);
      if (filtered_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transfer %p", got);
      end else begin
        exp_pix = filtered_q.pop_front();
        if (got.x !== exp_pix.x || got.y !== exp_pix.y || got.v0 !== exp_pix.v0 ||
            got.v1 !== exp_pix.v1 || got.v2 !== exp_pix.v2 ||
            got.last_run !== exp_pix.last_run || got.last_frame !== exp_pix.last_frame) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_pix, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_tables();
    test_extremes();
    test_size_clamps();
    test_random_frames();
    in_valid <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
